// ===== src/bcs_pkg.sv =====
// ----------------------------------------------------------------------------
// bcs_pkg: Bezier curve sampler package
// Shared constants, sequencer state type and the sample parameter table.
// ----------------------------------------------------------------------------
package bcs_pkg;

    localparam int BCS_MAX_POINTS = 16;
    localparam int SAMPLE_COUNT   = 11;
    localparam int K_W            = $clog2(SAMPLE_COUNT);
    localparam int COORD_W        = 16;
    localparam int WORK_W         = 32;
    localparam int OUT_W          = 24;
    localparam int T_W            = 17;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_MUL,
        ST_WR,
        ST_FETCH,
        ST_EMIT
    } bcs_state_t;

    // t = k/10 in Q1.16, rounded to nearest; 65536 is t = 1.0
    function automatic logic [T_W-1:0] t_of_k(input logic [K_W-1:0] k);
        logic [T_W-1:0] t;
        case (k)
            4'd0:    t = 17'd0;
            4'd1:    t = 17'd6554;
            4'd2:    t = 17'd13107;
            4'd3:    t = 17'd19661;
            4'd4:    t = 17'd26214;
            4'd5:    t = 17'd32768;
            4'd6:    t = 17'd39322;
            4'd7:    t = 17'd45875;
            4'd8:    t = 17'd52429;
            4'd9:    t = 17'd58982;
            4'd10:   t = 17'd65536;
            default: t = 17'd0;
        endcase
        return t;
    endfunction

endpackage

// ===== src/bcs_lerp.sv =====
// ----------------------------------------------------------------------------
// bcs_lerp: shared Q16.16 linear interpolation unit
// Registers p and (q-p)*t; result is p + floor((q-p)*t / 2^16).
// ----------------------------------------------------------------------------
module bcs_lerp
    import bcs_pkg::*;
(
    input  logic              clk,
    input  logic              load,
    input  logic [WORK_W-1:0] p,
    input  logic [WORK_W-1:0] q,
    input  logic [T_W-1:0]    t,
    output logic [WORK_W-1:0] res
);

    localparam int DIFF_W = WORK_W + 1;
    localparam int PROD_W = DIFF_W + T_W + 1;

    logic signed [DIFF_W-1:0] diff;
    logic signed [T_W:0]      t_s;
    logic signed [PROD_W-1:0] prod_reg;
    logic [WORK_W-1:0]        p_reg;

    assign diff = $signed({1'b0, q}) - $signed({1'b0, p});
    assign t_s  = $signed({1'b0, t});

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= diff * t_s;
            p_reg    <= p;
        end
    end

    // arithmetic shift by 16; low word suffices, result stays in the hull
    assign res = p_reg + WORK_W'(prod_reg[WORK_W+15:16]);

endmodule

// ===== src/bezier_curve_sampler.sv =====
// ----------------------------------------------------------------------------
// bezier_curve_sampler: de Casteljau Bezier curve evaluation
// Collects control points and emits 11 curve samples at t = k/10.
// ----------------------------------------------------------------------------
// Control points transfer at one per cycle and are stored in a memory. The
// point marked last_point starts evaluation, during which in_ready is low.
// Each of the 11 samples is computed in turn and may wait on out_ready:
// one interpolation unit per axis (x and y) runs the de Casteljau rounds,
// each interpolation being a registered memory read, a multiply and a
// write back. Points beyond MAX_POINTS are dropped; a dropped last point
// still starts evaluation of the points held. Outputs are Q16.8, truncated.
module bezier_curve_sampler
    import bcs_pkg::*;
#(
    parameter int MAX_POINTS = BCS_MAX_POINTS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [COORD_W-1:0] point_x,
    input  logic [COORD_W-1:0] point_y,
    input  logic               last_point,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [OUT_W-1:0]   curve_x,
    output logic [OUT_W-1:0]   curve_y,
    output logic               last_sample
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int IDX_W = $clog2(MAX_POINTS);

    bcs_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    i_reg, i_next;
    logic [IDX_W-1:0]    j_reg, j_next;
    logic [K_W-1:0]      k_reg, k_next;
    logic                first_reg, first_next;
    logic                out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]    curve_x_reg, curve_y_reg;
    logic                last_sample_reg;

    logic [COORD_W-1:0]  ctrl_x_mem [MAX_POINTS];
    logic [COORD_W-1:0]  ctrl_y_mem [MAX_POINTS];
    logic [WORK_W-1:0]   work_x_mem [MAX_POINTS];
    logic [WORK_W-1:0]   work_y_mem [MAX_POINTS];
    logic [COORD_W-1:0]  cx_a_reg, cx_b_reg, cy_a_reg, cy_b_reg;
    logic [WORK_W-1:0]   wx_a_reg, wx_b_reg, wy_a_reg, wy_b_reg;

    logic                in_xfer, out_free, store_full, single, lerp_load, load_out;
    logic                round_end;
    logic [IDX_W-1:0]    rd_a, rd_b;
    logic [WORK_W-1:0]   px, qx, py, qy, rx, ry, ex, ey;
    logic [T_W-1:0]      t_cur;

    assign in_ready   = (state_reg == ST_IDLE);
    assign in_xfer    = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign store_full = (count_reg == CNT_W'(MAX_POINTS));
    assign single     = (count_reg == CNT_W'(1));
    assign round_end  = (i_reg == j_reg - 1'b1);
    assign t_cur      = t_of_k(k_reg);

    // control store: written on point transfer while not full
    always_ff @(posedge clk)
    begin
        if (in_xfer && !store_full)
        begin
            ctrl_x_mem[count_reg[IDX_W-1:0]] <= point_x;
            ctrl_y_mem[count_reg[IDX_W-1:0]] <= point_y;
        end
    end

    assign rd_a = (state_reg == ST_FETCH) ? '0 : i_reg;
    assign rd_b = i_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        cx_a_reg <= ctrl_x_mem[rd_a];
        cx_b_reg <= ctrl_x_mem[rd_b];
        cy_a_reg <= ctrl_y_mem[rd_a];
        cy_b_reg <= ctrl_y_mem[rd_b];
    end

    // work store: one write, two registered reads
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WR)
        begin
            work_x_mem[i_reg] <= rx;
            work_y_mem[i_reg] <= ry;
        end
        wx_a_reg <= work_x_mem[rd_a];
        wx_b_reg <= work_x_mem[rd_b];
        wy_a_reg <= work_y_mem[rd_a];
        wy_b_reg <= work_y_mem[rd_b];
    end

    // first round reads control points directly
    assign px = first_reg ? {cx_a_reg, 16'd0} : wx_a_reg;
    assign qx = first_reg ? {cx_b_reg, 16'd0} : wx_b_reg;
    assign py = first_reg ? {cy_a_reg, 16'd0} : wy_a_reg;
    assign qy = first_reg ? {cy_b_reg, 16'd0} : wy_b_reg;
    assign lerp_load = (state_reg == ST_MUL);

    bcs_lerp u_lerp_x
    (
        .clk  (clk),
        .load (lerp_load),
        .p    (px),
        .q    (qx),
        .t    (t_cur),
        .res  (rx)
    );

    bcs_lerp u_lerp_y
    (
        .clk  (clk),
        .load (lerp_load),
        .p    (py),
        .q    (qy),
        .t    (t_cur),
        .res  (ry)
    );

    assign ex = single ? {cx_a_reg, 16'd0} : wx_a_reg;
    assign ey = single ? {cy_a_reg, 16'd0} : wy_a_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && last_point)
                begin
                    state_next = (store_full || count_reg != '0) ? ST_RD : ST_FETCH;
                end
            end
            ST_RD:    state_next = ST_MUL;
            ST_MUL:   state_next = ST_WR;
            ST_WR:    state_next = (round_end && j_reg == IDX_W'(1)) ? ST_FETCH : ST_RD;
            ST_FETCH: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                begin
                    if (k_reg == K_W'(SAMPLE_COUNT - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = single ? ST_FETCH : ST_RD;
                    end
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // counters and output register control
    always_comb
    begin
        count_next     = count_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        first_next     = first_reg;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (!store_full)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    if (last_point)
                    begin
                        k_next     = '0;
                        i_next     = '0;
                        first_next = 1'b1;
                        j_next     = store_full ? IDX_W'(MAX_POINTS - 1) : count_reg[IDX_W-1:0];
                    end
                end
            end
            ST_RD, ST_MUL, ST_FETCH: ;
            ST_WR:
            begin
                if (round_end)
                begin
                    i_next     = '0;
                    first_next = 1'b0;
                    if (j_reg != IDX_W'(1))
                    begin
                        j_next = j_reg - 1'b1;
                    end
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    k_next         = k_reg + 1'b1;
                    i_next         = '0;
                    first_next     = 1'b1;
                    j_next         = IDX_W'(count_reg - 1'b1);
                    if (k_reg == K_W'(SAMPLE_COUNT - 1))
                    begin
                        count_next = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            curve_x_reg     <= ex[WORK_W-1:8];
            curve_y_reg     <= ey[WORK_W-1:8];
            last_sample_reg <= (k_reg == K_W'(SAMPLE_COUNT - 1));
        end
    end

    assign out_valid   = out_valid_reg;
    assign curve_x     = curve_x_reg;
    assign curve_y     = curve_y_reg;
    assign last_sample = last_sample_reg;

    a_last_starts_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && last_point) |=> !in_ready)
        else $error("evaluation did not start after last point");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count beyond store depth");

    a_wr_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |=> (state_reg == ST_WR))
        else $error("write back did not follow multiply");

    a_idle_no_pending_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_free && k_reg == K_W'(SAMPLE_COUNT - 1))
        |=> (count_reg == '0 && out_valid && last_sample))
        else $error("final sample transfer setup wrong");

endmodule

// ===== test/tb_bezier_curve_sampler.sv =====
// ----------------------------------------------------------------------------
// tb_bezier_curve_sampler: testbench for the Bezier curve sampler
// Sends curves of control points over the input channel. For each curve the
// scoreboard predicts the 11 de Casteljau samples. Each sample from the
// output channel is checked against the oldest predicted one. Both sides
// idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_bezier_curve_sampler
    import bcs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES  = 7;
    localparam int MAX_GAP       = 18;
    localparam int LONG_HOLD     = 400;
    localparam int HOLD_AFTER    = 150;
    localparam int TARGET_POINTS = 350;
    localparam int DRAIN_CYCLES  = 400;
    localparam int IDLE_LIMIT    = 5000;

    typedef struct packed {
        logic [OUT_W-1:0] x;
        logic [OUT_W-1:0] y;
        logic             is_last;
    } curve_point_t;

    class curve_scoreboard;
        logic [COORD_W-1:0] held_x[$];
        logic [COORD_W-1:0] held_y[$];
        curve_point_t       curve_q[$];
        int                 errors;
        int                 points_checked;

        function new();
            errors = 0;
            points_checked = 0;
        endfunction

        // p + floor((q - p) * t / 2^16), Q16.16
        function logic [WORK_W-1:0] lerp(logic [WORK_W-1:0] p, logic [WORK_W-1:0] q,
                                         logic [T_W-1:0] t);
            logic [48:0] prod;
            if (q >= p)
            begin
                prod = (q - p) * t;
                return p + prod[47:16];
            end
            prod = (p - q) * t + 49'd65535;
            return p - prod[47:16];
        endfunction

        function void note_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                 logic is_last);
            logic [WORK_W-1:0] wx [BCS_MAX_POINTS];
            logic [WORK_W-1:0] wy [BCS_MAX_POINTS];
            logic [T_W-1:0]    t;
            curve_point_t      s;
            int                n;
            if (held_x.size() < BCS_MAX_POINTS)
            begin
                held_x.push_back(x);
                held_y.push_back(y);
            end
            if (!is_last)
                return;
            n = held_x.size();
            for (int k = 0; k < SAMPLE_COUNT; k++)
            begin
                t = T_W'((k * 65536 + 5) / 10);
                for (int i = 0; i < n; i++)
                begin
                    wx[i] = {held_x[i], 16'h0000};
                    wy[i] = {held_y[i], 16'h0000};
                end
                for (int j = n - 1; j > 0; j--)
                    for (int i = 0; i < j; i++)
                    begin
                        wx[i] = lerp(wx[i], wx[i + 1], t);
                        wy[i] = lerp(wy[i], wy[i + 1], t);
                    end
                s.x       = OUT_W'(wx[0] >> 8);
                s.y       = OUT_W'(wy[0] >> 8);
                s.is_last = (k == SAMPLE_COUNT - 1);
                curve_q.push_back(s);
            end
            held_x.delete();
            held_y.delete();
        endfunction

        function void check_point(logic [OUT_W-1:0] x, logic [OUT_W-1:0] y,
                                  logic is_last);
            curve_point_t exp_pt;
            points_checked++;
            if (curve_q.size() == 0)
            begin
                $display("%0t: unexpected curve point x=%h y=%h last=%b",
                         $time, x, y, is_last);
                errors++;
                return;
            end
            exp_pt = curve_q.pop_front();
            if (x !== exp_pt.x)
            begin
                $display("%0t: curve_x expected %h actual %h", $time, exp_pt.x, x);
                errors++;
            end
            if (y !== exp_pt.y)
            begin
                $display("%0t: curve_y expected %h actual %h", $time, exp_pt.y, y);
                errors++;
            end
            if (is_last !== exp_pt.is_last)
            begin
                $display("%0t: last_sample expected %b actual %b",
                         $time, exp_pt.is_last, is_last);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic               last_point;
    logic               out_valid;
    logic               out_ready;
    logic [OUT_W-1:0]   curve_x;
    logic [OUT_W-1:0]   curve_y;
    logic               last_sample;

    curve_scoreboard sb;
    int              points_sent;
    int              idle_cycles;
    bit              send_burst;

    bezier_curve_sampler i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .point_x     (point_x),
        .point_y     (point_y),
        .last_point  (last_point),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .curve_x     (curve_x),
        .curve_y     (curve_y),
        .last_sample (last_sample)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        point_x    = '0;
        point_y    = '0;
        last_point = 1'b0;
        out_ready  = 1'b0;
        sb         = new();
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
        else
            idle_cycles <= 0;
    end

    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return COORD_W'($urandom_range(0, 255));
            default: return COORD_W'($urandom);
        endcase
    endfunction

    task automatic drive_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                               logic is_last);
        int gap;
        if ($urandom_range(0, 15) == 0)
            send_burst = ~send_burst;
        gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        point_x    <= x;
        point_y    <= y;
        last_point <= is_last;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_point(x, y, is_last);
        points_sent++;
    endtask

    task automatic send_curve(int len);
        for (int i = 0; i < len; i++)
            drive_point(pick_coord(), pick_coord(), i == len - 1);
    endtask

    // receiver
    initial
    begin
        int  gap;
        bit  burst;
        bit  hold_done;
        burst = 1'b0;
        hold_done = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                burst = ~burst;
            gap = burst ? 0 : $urandom_range(0, MAX_GAP);
            if (!hold_done && sb.points_checked >= HOLD_AFTER)
            begin
                gap = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            sb.check_point(curve_x, curve_y, last_sample);
        end
    end

    initial
    begin
        int r;
        int len;
        points_sent = 0;
        send_burst  = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-point curves at the extremes
        drive_point('0, '0, 1'b1);
        drive_point('1, '1, 1'b1);
        // straight lines, rising and falling, then a three-point curve
        drive_point('0, '0, 1'b0);
        drive_point('1, '1, 1'b1);
        drive_point('1, '1, 1'b0);
        drive_point('0, '0, 1'b1);
        drive_point('0, '1, 1'b0);
        drive_point('1, '0, 1'b0);
        drive_point(16'h1234, 16'hABCD, 1'b1);
        // full store, then a last point that is dropped
        for (int i = 0; i < BCS_MAX_POINTS; i++)
            drive_point(i[0] ? '1 : '0, i[1] ? '0 : '1, 1'b0);
        drive_point(16'h5A5A, 16'hA5A5, 1'b1);

        while (points_sent < TARGET_POINTS)
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
                len = $urandom_range(1, 5);
            else if (r < 88)
                len = $urandom_range(6, BCS_MAX_POINTS);
            else
                len = $urandom_range(BCS_MAX_POINTS + 1, BCS_MAX_POINTS + 4);
            send_curve(len);
        end
        in_valid <= 1'b0;

        while (sb.curve_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
